>>> rtl/sdf_pkg.sv
`timescale 1ns / 1ps

package sdf_pkg;

    // one spring, all fields Q16.16
    typedef struct packed {
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
        logic signed [31:0] rel_vel_x;
        logic signed [31:0] rel_vel_y;
        logic signed [31:0] rel_vel_z;
        logic        [30:0] rest_length;
        logic        [30:0] stiffness;
    } sdf_in_t;

    // force on end b
    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               skipped;
    } sdf_out_t;

    localparam int ADDR_W      = 3;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 17;
    localparam int LEN_MIN_LSB = 7;

    // register index of the damping factor (paddr[2])
    localparam logic REG_DAMPING = 1'b0;

endpackage

>>> rtl/spring_damper_force.sv
`timescale 1ns / 1ps

// channel   ports                                  transfer
// -------   -------------------------------------  -----------------------------------
// item in   start, busy, item                      start high and busy low at clk edge
// result    done, result                           done high for one cycle, no backpressure
// config    psel, penable, pwrite, paddr, pwdata,  apb write at access phase, pready = 1
//           prdata, pready
//
// fully pipelined: one item per cycle
// the pipe holds the 32-stage square root and the 17-stage divider, one bit per stage
// busy is always low; results come out in order, one per accepted item
// rst_n clears only the valid bits and the damping register (to zero)
// the receiver cannot stall, so nothing in the pipe ever holds
module spring_damper_force
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sdf_pkg::sdf_in_t            item,
    output logic                        done,
    output sdf_pkg::sdf_out_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdf_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sdf_pkg::*;

    // payload carried along the square root
    typedef struct packed {
        logic [2:0][31:0]        dmag;
        logic [2:0]              dneg;
        logic [2:0][31:0]        vel;
        logic [30:0]             rest;
        logic [30:0]             k;
    } sq_carry_t;

    // payload carried along the divider
    typedef struct packed {
        logic [2:0]              dneg;
        logic [2:0][31:0]        vel;
        logic [30:0]             k;
        logic [32:0]             disp_mag;
        logic                    disp_neg;
        logic                    skip;
    } dv_carry_t;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [30:0] damping_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= '0;
        end
        else if (cfg_wr && paddr[2] == REG_DAMPING)
        begin
            damping_reg <= pwdata[30:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_DAMPING)
        begin
            prdata = {1'b0, damping_reg};
        end
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage in: register the item, displacements as sign and magnitude
    // ------------------------------------------------------------------
    logic      in_vld_reg;
    sq_carry_t in_pl_reg;
    sq_carry_t in_pl_next;

    always_comb
    begin
        in_pl_next.dneg   = {item.delta_z[31], item.delta_y[31], item.delta_x[31]};
        in_pl_next.dmag[0] = item.delta_x[31] ? 32'(-item.delta_x) : item.delta_x;
        in_pl_next.dmag[1] = item.delta_y[31] ? 32'(-item.delta_y) : item.delta_y;
        in_pl_next.dmag[2] = item.delta_z[31] ? 32'(-item.delta_z) : item.delta_z;
        in_pl_next.vel[0] = item.rel_vel_x;
        in_pl_next.vel[1] = item.rel_vel_y;
        in_pl_next.vel[2] = item.rel_vel_z;
        in_pl_next.rest   = item.rest_length;
        in_pl_next.k      = item.stiffness;
    end

    // squares
    logic             sqr_vld_reg;
    logic [2:0][63:0] sqr_reg;
    sq_carry_t        sqr_pl_reg;

    // sum of squares
    logic             sum_vld_reg;
    logic [63:0]      sum_reg;
    sq_carry_t        sum_pl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            sqr_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start;
            sqr_vld_reg <= in_vld_reg;
            sum_vld_reg <= sqr_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_pl_reg  <= in_pl_next;
        for (int i = 0; i < 3; i++)
        begin
            sqr_reg[i] <= in_pl_reg.dmag[i] * in_pl_reg.dmag[i];
        end
        sqr_pl_reg <= in_pl_reg;
        sum_reg    <= sqr_reg[0] + sqr_reg[1] + sqr_reg[2];
        sum_pl_reg <= sqr_pl_reg;
    end

    // ------------------------------------------------------------------
    // integer square root, one result bit per stage
    // ------------------------------------------------------------------
    logic [SQRT_STEPS:0]       sq_vld_reg;
    logic [SQRT_STEPS:0][63:0] sq_x_reg;
    logic [SQRT_STEPS:0][34:0] sq_rem_reg;
    logic [SQRT_STEPS:0][31:0] sq_root_reg;
    sq_carry_t [SQRT_STEPS:0]  sq_pl_reg;

    assign sq_vld_reg[0]  = sum_vld_reg;
    assign sq_x_reg[0]    = sum_reg;
    assign sq_rem_reg[0]  = '0;
    assign sq_root_reg[0] = '0;
    assign sq_pl_reg[0]   = sum_pl_reg;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [34:0] rem_sh;
        logic [34:0] trial;
        logic [34:0] rem_next;
        logic [31:0] root_next;

        always_comb
        begin
            rem_sh = {sq_rem_reg[j][32:0], sq_x_reg[j][63:62]};
            trial  = {1'b0, sq_root_reg[j], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {sq_root_reg[j][30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {sq_root_reg[j][30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_x_reg[j+1]    <= {sq_x_reg[j][61:0], 2'b00};
            sq_rem_reg[j+1]  <= rem_next;
            sq_root_reg[j+1] <= root_next;
            sq_pl_reg[j+1]   <= sq_pl_reg[j];
        end
    end

    // ------------------------------------------------------------------
    // divider entry: length, displacement, short spring flag
    // ------------------------------------------------------------------
    logic [31:0] len;
    logic [32:0] disp_s;
    dv_carry_t   dv_entry;

    assign len    = sq_root_reg[SQRT_STEPS];
    assign disp_s = {1'b0, len} - {2'b00, sq_pl_reg[SQRT_STEPS].rest};

    always_comb
    begin
        dv_entry.dneg     = sq_pl_reg[SQRT_STEPS].dneg;
        dv_entry.vel      = sq_pl_reg[SQRT_STEPS].vel;
        dv_entry.k        = sq_pl_reg[SQRT_STEPS].k;
        dv_entry.disp_neg = disp_s[32];
        dv_entry.disp_mag = disp_s[32] ? 33'(-disp_s) : disp_s;
        dv_entry.skip     = (len < 32'(LEN_MIN_LSB));
    end

    logic [DIV_STEPS:0]            dv_vld_reg;
    logic [DIV_STEPS:0][31:0]      dv_len_reg;
    logic [DIV_STEPS:0][2:0][32:0] dv_r_reg;
    logic [DIV_STEPS:0][2:0][16:0] dv_q_reg;
    dv_carry_t [DIV_STEPS:0]       dv_pl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else
        begin
            dv_vld_reg[0] <= sq_vld_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_len_reg[0] <= len;
        for (int i = 0; i < 3; i++)
        begin
            dv_r_reg[0][i] <= {1'b0, sq_pl_reg[SQRT_STEPS].dmag[i]};
        end
        dv_q_reg[0]  <= '0;
        dv_pl_reg[0] <= dv_entry;
    end

    // unit direction: q = (|d| << 16) / len, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [2:0][32:0] r_next;
        logic [2:0][16:0] q_next;

        always_comb
        begin
            logic [33:0] cand;
            for (int i = 0; i < 3; i++)
            begin
                // first step compares |d| itself, later steps bring in a zero
                cand = (j == 0) ? {1'b0, dv_r_reg[j][i]} : {dv_r_reg[j][i], 1'b0};
                if (cand >= {2'b00, dv_len_reg[j]})
                begin
                    r_next[i] = 33'(cand - {2'b00, dv_len_reg[j]});
                    q_next[i] = {dv_q_reg[j][i][15:0], 1'b1};
                end
                else
                begin
                    r_next[i] = cand[32:0];
                    q_next[i] = {dv_q_reg[j][i][15:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_len_reg[j+1] <= dv_len_reg[j];
            dv_r_reg[j+1]   <= r_next;
            dv_q_reg[j+1]   <= q_next;
            dv_pl_reg[j+1]  <= dv_pl_reg[j];
        end
    end

    // ------------------------------------------------------------------
    // force terms, sign and magnitude with truncation toward zero
    // ------------------------------------------------------------------
    dv_carry_t        dv_out;
    logic [2:0][16:0] qmag;

    assign dv_out = dv_pl_reg[DIV_STEPS];
    assign qmag   = dv_q_reg[DIV_STEPS];

    // m1: spring scalar, v_i * u_i
    logic                    m1_vld_reg;
    logic [47:0]             m1_ss_mag_reg;
    logic                    m1_ss_neg_reg;
    logic [2:0][49:0]        m1_vu_reg;
    logic [2:0][16:0]        m1_q_reg;
    logic [2:0]              m1_uneg_reg;
    logic                    m1_skip_reg;
    logic [63:0]             ss_prod;

    assign ss_prod = {33'd0, dv_out.k} * {31'd0, dv_out.disp_mag};

    always_ff @(posedge clk)
    begin
        m1_ss_mag_reg <= ss_prod[63:16];
        m1_ss_neg_reg <= ~dv_out.disp_neg;
        for (int i = 0; i < 3; i++)
        begin
            m1_vu_reg[i] <= 50'($signed(dv_out.vel[i]) * (dv_out.dneg[i]
                            ? -$signed({1'b0, qmag[i]}) : $signed({1'b0, qmag[i]})));
        end
        m1_q_reg    <= qmag;
        m1_uneg_reg <= dv_out.dneg;
        m1_skip_reg <= dv_out.skip;
    end

    // m2: velocity along the axis, spring term per axis
    logic                    m2_vld_reg;
    logic [35:0]             m2_al_mag_reg;
    logic                    m2_al_neg_reg;
    logic [2:0][48:0]        m2_ps_reg;
    logic [2:0]              m2_ps_neg_reg;
    logic [2:0][16:0]        m2_q_reg;
    logic [2:0]              m2_uneg_reg;
    logic                    m2_skip_reg;
    logic signed [51:0]      al_sum;
    logic [51:0]             al_abs;

    assign al_sum = 52'($signed(m1_vu_reg[0])) + 52'($signed(m1_vu_reg[1]))
                  + 52'($signed(m1_vu_reg[2]));
    assign al_abs = al_sum[51] ? 52'(-al_sum) : al_sum;

    always_ff @(posedge clk)
    begin
        logic [64:0] pprod;
        m2_al_mag_reg <= al_abs[51:16];
        m2_al_neg_reg <= al_sum[51];
        for (int i = 0; i < 3; i++)
        begin
            pprod            = {17'd0, m1_ss_mag_reg} * {48'd0, m1_q_reg[i]};
            m2_ps_reg[i]     <= pprod[64:16];
            m2_ps_neg_reg[i] <= m1_ss_neg_reg ^ m1_uneg_reg[i];
        end
        m2_q_reg    <= m1_q_reg;
        m2_uneg_reg <= m1_uneg_reg;
        m2_skip_reg <= m1_skip_reg;
    end

    // m3: damping scalar
    logic                    m3_vld_reg;
    logic [50:0]             m3_sd_mag_reg;
    logic                    m3_sd_neg_reg;
    logic [2:0][48:0]        m3_ps_reg;
    logic [2:0]              m3_ps_neg_reg;
    logic [2:0][16:0]        m3_q_reg;
    logic [2:0]              m3_uneg_reg;
    logic                    m3_skip_reg;
    logic [66:0]             sd_prod;

    assign sd_prod = {36'd0, damping_reg} * {31'd0, m2_al_mag_reg};

    always_ff @(posedge clk)
    begin
        m3_sd_mag_reg <= sd_prod[66:16];
        m3_sd_neg_reg <= ~m2_al_neg_reg;
        m3_ps_reg     <= m2_ps_reg;
        m3_ps_neg_reg <= m2_ps_neg_reg;
        m3_q_reg      <= m2_q_reg;
        m3_uneg_reg   <= m2_uneg_reg;
        m3_skip_reg   <= m2_skip_reg;
    end

    // m4: damping term per axis
    logic                    m4_vld_reg;
    logic [2:0][51:0]        m4_pd_reg;
    logic [2:0]              m4_pd_neg_reg;
    logic [2:0][48:0]        m4_ps_reg;
    logic [2:0]              m4_ps_neg_reg;
    logic                    m4_skip_reg;

    always_ff @(posedge clk)
    begin
        logic [67:0] dprod;
        for (int i = 0; i < 3; i++)
        begin
            dprod            = {17'd0, m3_sd_mag_reg} * {51'd0, m3_q_reg[i]};
            m4_pd_reg[i]     <= dprod[67:16];
            m4_pd_neg_reg[i] <= m3_sd_neg_reg ^ m3_uneg_reg[i];
        end
        m4_ps_reg     <= m3_ps_reg;
        m4_ps_neg_reg <= m3_ps_neg_reg;
        m4_skip_reg   <= m3_skip_reg;
    end

    // m5: add, saturate, zero on short spring
    sdf_out_t         result_next;

    always_comb
    begin
        logic signed [53:0] ps_s;
        logic signed [53:0] pd_s;
        logic signed [53:0] tot;
        logic signed [31:0] sat [3];
        for (int i = 0; i < 3; i++)
        begin
            ps_s = m4_ps_neg_reg[i] ? -$signed({5'd0, m4_ps_reg[i]})
                                    : $signed({5'd0, m4_ps_reg[i]});
            pd_s = m4_pd_neg_reg[i] ? -$signed({2'd0, m4_pd_reg[i]})
                                    : $signed({2'd0, m4_pd_reg[i]});
            tot  = ps_s + pd_s;
            if (tot > 54'sd2147483647)
            begin
                sat[i] = 32'sh7fffffff;
            end
            else if (tot < -54'sd2147483648)
            begin
                sat[i] = 32'sh80000000;
            end
            else
            begin
                sat[i] = tot[31:0];
            end
            if (m4_skip_reg)
            begin
                sat[i] = '0;
            end
        end
        result_next.force_x = sat[0];
        result_next.force_y = sat[1];
        result_next.force_z = sat[2];
        result_next.skipped = m4_skip_reg;
    end

    logic     done_reg;
    sdf_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
            m4_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= dv_vld_reg[DIV_STEPS];
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
            m4_vld_reg <= m3_vld_reg;
            done_reg   <= m4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
